### rtl/national_id_check_digit_validator_defines.svh
// ----------------------------------------------------------------------------
// National ID check digit validator: assertion macros
// Shared helpers for the concurrent checks of the validator.
// ----------------------------------------------------------------------------
`ifndef NATIONAL_ID_CHECK_DIGIT_VALIDATOR_DEFINES_SVH
`define NATIONAL_ID_CHECK_DIGIT_VALIDATOR_DEFINES_SVH

// Property checked on the rising clock edge, ignored while reset is asserted.
`define NCDV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define NCDV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ncdv_pkg.sv
// ----------------------------------------------------------------------------
// ncdv_pkg
// Constants and helpers shared by the check digit validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ncdv_pkg;

  // Number of decimal digits in an identity number, check digit included.
  localparam int DIGIT_COUNT_DEF = 10;

  // Width of the binary identity number.
  localparam int ID_W = 34;

  // Binary bits folded into the BCD value by one pipeline stage.
  localparam int STEP = 4;

  // Conversion stages and the zero-padded input width they consume.
  localparam int DABBLE_STAGES = (ID_W + STEP - 1) / STEP;
  localparam int PAD_W         = DABBLE_STAGES * STEP;

  // Register stages from input to result: conversion, sum, result.
  localparam int PIPE_DEPTH = DABBLE_STAGES + 2;

  // Width of one decimal digit and of the check digit.
  localparam int CHECK_W = 4;

  // The check digit base.
  localparam logic [CHECK_W-1:0] CHECK_BASE = 4'd10;

  // x / 10 equals (x * RECIP) >> RECIP_SH for every x below 1029.
  localparam int RECIP    = 205;
  localparam int RECIP_W  = 8;
  localparam int RECIP_SH = 11;

  // Doubles a digit and folds a two-digit product back by subtracting nine.
  function automatic logic [CHECK_W-1:0] doubled_digit(input logic [CHECK_W-1:0] d);
    logic [CHECK_W:0] twice;
    twice = {d, 1'b0};
    if (twice > 5'd9) begin
      doubled_digit = CHECK_W'(twice - 5'd9);
    end else begin
      doubled_digit = twice[CHECK_W-1:0];
    end
  endfunction

endpackage

### rtl/ncdv_dabble_stage.sv
// ----------------------------------------------------------------------------
// ncdv_dabble_stage
// One pipeline stage of the binary to BCD conversion (shift and add three).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncdv_dabble_stage #(
  parameter int NDIG  = ncdv_pkg::DIGIT_COUNT_DEF,
  parameter int BIN_W = ncdv_pkg::PAD_W,
  parameter int STEP  = ncdv_pkg::STEP
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [4*NDIG-1:0] bcd_i,
  input  logic [BIN_W-1:0]  bin_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [4*NDIG-1:0] bcd_o,
  output logic [BIN_W-1:0]  bin_o
);

  localparam int BCD_W = 4 * NDIG;

  // Folds STEP bits, most significant first, into the BCD value. A carry out
  // of the top digit is dropped, which keeps the value modulo 10^NDIG.
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
                                               input logic [STEP-1:0]  bits);
    logic [BCD_W-1:0] t;
    t = b;
    for (int s = STEP - 1; s >= 0; s--) begin
      for (int d = 0; d < NDIG; d++) begin
        if (t[4*d +: 4] >= 4'd5) begin
          t[4*d +: 4] = t[4*d +: 4] + 4'd3;
        end
      end
      t = {t[BCD_W-2:0], bits[s]};
    end
    return t;
  endfunction

  logic             valid_q;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [BIN_W-1:0] bin_q, bin_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    bcd_d = dabble(bcd_i, bin_i[BIN_W-1 -: STEP]);
    bin_d = bin_i << STEP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;

endmodule

### rtl/national_id_check_digit_validator.sv
// ----------------------------------------------------------------------------
// national_id_check_digit_validator
// From input transfer to result: 9 conversion stages, one digit sum stage,
// one result stage. Throughput: one number per cycle while the output is
// not stalled, set by the shift-and-add-three conversion pipeline. Reset
// clears the valid bit of every stage; data registers keep whatever they hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module national_id_check_digit_validator #(
  parameter int DIGIT_COUNT = ncdv_pkg::DIGIT_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ncdv_pkg::ID_W-1:0]   id_number_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        is_valid_o,
  output logic [ncdv_pkg::CHECK_W-1:0] computed_check_o
);

  // The binary number is turned into DIGIT_COUNT BCD digits by a pipelined
  // shift-and-add-three converter, STEP bits per stage. Any carry beyond the
  // top digit falls away, so numbers above ten digits are taken modulo 10^10
  // and short numbers come out with leading zero digits.
  localparam int BCD_W  = 4 * DIGIT_COUNT;
  localparam int NSTG   = ncdv_pkg::DABBLE_STAGES;
  localparam int PAD_W  = ncdv_pkg::PAD_W;
  localparam int DIG_W  = ncdv_pkg::CHECK_W;
  localparam int SUM_W  = $clog2(9 * (DIGIT_COUNT - 1) + 1);
  localparam int PROD_W = SUM_W + ncdv_pkg::RECIP_W;

  logic             valid_s [0:NSTG];
  logic             ready_s [0:NSTG];
  logic [BCD_W-1:0] bcd_s   [0:NSTG];
  logic [PAD_W-1:0] bin_s   [0:NSTG];

  // The input enters the first conversion stage with an empty BCD value and
  // zero padding above the number, which leaves the value unchanged.
  assign valid_s[0]  = in_valid_i;
  assign bcd_s[0]    = '0;
  assign bin_s[0]    = PAD_W'(id_number_i);
  assign in_stall_o  = !ready_s[0];

  for (genvar k = 0; k < NSTG; k++) begin : g_dabble
    ncdv_dabble_stage #(
      .NDIG  (DIGIT_COUNT),
      .BIN_W (PAD_W),
      .STEP  (ncdv_pkg::STEP)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .bcd_i   (bcd_s[k]),
      .bin_i   (bin_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .bcd_o   (bcd_s[k+1]),
      .bin_o   (bin_s[k+1])
    );
  end

  // The last conversion stage still carries binary bits, all of them shifted
  // out by now; only its BCD value goes on.

  // Digit sum stage. Counting from the left, odd positions are doubled and
  // folded, even positions are added as they are. The last digit is the
  // check digit and only travels along for the comparison.
  logic             sum_valid_q;
  logic             sum_ready;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [DIG_W-1:0] last_q;
  logic [DIG_W-1:0] digit;

  always_comb begin
    sum_d = '0;
    digit = '0;
    for (int k = 0; k < DIGIT_COUNT - 1; k++) begin
      digit = bcd_s[NSTG][4*(DIGIT_COUNT-1-k) +: 4];
      if ((k % 2) == 0) begin
        sum_d = sum_d + SUM_W'(ncdv_pkg::doubled_digit(digit));
      end else begin
        sum_d = sum_d + SUM_W'(digit);
      end
    end
  end

  assign sum_ready         = !sum_valid_q || !out_valid_o || !out_stall_i;
  assign ready_s[NSTG]     = sum_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (sum_ready) begin
      sum_valid_q <= valid_s[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && valid_s[NSTG]) begin
      sum_q  <= sum_d;
      last_q <= bcd_s[NSTG][DIG_W-1:0];
    end
  end

  // Result stage. The sum modulo ten comes from a multiplication by a scaled
  // reciprocal of ten; the check digit is ten minus that remainder, with a
  // zero remainder giving a zero check digit.
  logic              out_valid_q;
  logic              out_ready;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quot;
  logic [SUM_W-1:0]  rem_full;
  logic [DIG_W-1:0]  rem;
  logic [DIG_W-1:0]  chk_d, chk_q;
  logic              match_d, match_q;

  always_comb begin
    prod     = PROD_W'(sum_q) * PROD_W'(ncdv_pkg::RECIP);
    quot     = SUM_W'(prod >> ncdv_pkg::RECIP_SH);
    rem_full = sum_q - SUM_W'(quot * SUM_W'(ncdv_pkg::CHECK_BASE));
    rem      = rem_full[DIG_W-1:0];
    if (rem == '0) begin
      chk_d = '0;
    end else begin
      chk_d = ncdv_pkg::CHECK_BASE - rem;
    end
    match_d = (chk_d == last_q);
  end

  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && sum_valid_q) begin
      chk_q   <= chk_d;
      match_q <= match_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_valid_o       = match_q;
  assign computed_check_o = chk_q;

endmodule

### rtl/ncdv_checker.sv
// ----------------------------------------------------------------------------
// ncdv_checker
// Port-level checks of the validator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "national_id_check_digit_validator_defines.svh"

module ncdv_checker #(
  parameter int DEPTH = ncdv_pkg::PIPE_DEPTH
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [ncdv_pkg::ID_W-1:0]    id_number_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         is_valid_o,
  input logic [ncdv_pkg::CHECK_W-1:0] computed_check_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             in_xfer;
  logic             out_xfer;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // Numbers taken in whose results have not been transferred yet.
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `NCDV_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(is_valid_o) && $stable(computed_check_o), "stalled result changed")
  `NCDV_ASSERT(a_check_range, clk_i, rst_ni, out_valid_o |-> computed_check_o <= 4'd9, "check digit above nine")
  `NCDV_ASSERT(a_no_phantom, clk_i, rst_ni, cnt_q == '0 |-> !out_valid_o, "result without a number in flight")
  `NCDV_ASSERT(a_empty_ready, clk_i, rst_ni, cnt_q == '0 |-> !in_stall_o, "empty pipeline stalls input")
  `NCDV_ASSERT(a_depth, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH), "more numbers in flight than stages")

  // The identity number is only watched through the transfer count.
  logic unused_id;
  assign unused_id = ^id_number_i;

endmodule

bind national_id_check_digit_validator ncdv_checker #(
  .DEPTH (ncdv_pkg::PIPE_DEPTH)
) u_ncdv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .id_number_i      (id_number_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .is_valid_o       (is_valid_o),
  .computed_check_o (computed_check_o)
);
